@@ rtl/core/cpsat_pkg.sv @@
package cpsat_pkg;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_EDGE0 = 6'b000010,
    ST_EDGE1 = 6'b000100,
    ST_PROJ  = 6'b001000,
    ST_JUDGE = 6'b010000,
    ST_OUT   = 6'b100000
  } cpsat_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic store_v;     // write the incoming vertex
    logic clear;       // start a new pair
    logic edge_rd0;    // read edge start vertex
    logic edge_rd1;    // read edge end vertex, form normal
    logic proj_start;  // reset the interval trackers
    logic proj_step;   // project one vertex
    logic next_edge;   // advance to next edge
  } cpsat_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic empty;       // one polygon holds no vertex
    logic proj_done;   // last vertex's projection accumulated
    logic separates;   // current normal separates
    logic edges_done;  // the current edge was the last of B
  } cpsat_sts_t;

endpackage

@@ rtl/core/convex_polygon_sat_overlap.sv @@
// Separating-axis overlap test for two convex polygons.
//
// Input channel (in_valid/in_ready): one vertex word per cycle, polygon A
// first (which_polygon = 0), then polygon B; last_vertex closes a polygon.
// Extra vertices beyond MAX_VERTICES are dropped and set overflow_flag.
// Output channel (out_valid/out_ready): one result word after B closes:
// colliding, or first separating polygon and edge; neither if A is empty.
//
// Sequence: for each edge tried, start and end vertex reads, then normal
// forming, then one vertex read per cycle over nA+nB vertices through the
// multiply and accumulate stages, then the judge. Each vertex store has a
// single read port.
// While a test runs or a result waits, in_ready is low: the block holds
// one pair at a time. A stalled receiver holds the result word stable.
// Reset (rst, synchronous) empties both polygons and drops any result.
module convex_polygon_sat_overlap import cpsat_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               which_polygon,
  input  logic signed [15:0] vertex_x,
  input  logic signed [15:0] vertex_y,
  input  logic               last_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               colliding,
  output logic               separating_polygon,
  output logic [3:0]         separating_edge,
  output logic               overflow_flag
);

  cpsat_cmd_t cmd;
  cpsat_sts_t sts;
  logic       res_load, res_coll;

  cpsat_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .which_polygon, .last_vertex,
    .out_valid, .out_ready, .cmd, .sts, .res_load, .res_coll
  );

  cpsat_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk, .rst, .cmd, .sts, .which_polygon, .vertex_x, .vertex_y,
    .last_vertex, .res_load, .res_coll, .colliding,
    .separating_polygon, .separating_edge, .overflow_flag
  );

  // never accept and present a result at once
  a_in_out: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // a colliding result carries no separating edge
  a_coll: assert property (@(posedge clk) disable iff (rst)
    out_valid && colliding |-> separating_edge == 4'd0 && !separating_polygon)
    else $error("colliding result with edge");

  // after the result is taken, the block loads again
  a_ret: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("no return to load");

endmodule

@@ rtl/core/cpsat_ctrl.sv @@
module cpsat_ctrl import cpsat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       which_polygon,
  input  logic       last_vertex,
  output logic       out_valid,
  input  logic       out_ready,
  output cpsat_cmd_t cmd,
  input  cpsat_sts_t sts,
  output logic       res_load,
  output logic       res_coll
);

  cpsat_state_t state, state_next;

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    res_load       = 1'b0;
    res_coll       = 1'b0;
    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.store_v = 1'b1;
          if (which_polygon && last_vertex) begin
            if (sts.empty) begin
              res_load   = 1'b1;
              state_next = ST_OUT;
            end else begin
              state_next = ST_EDGE0;
            end
          end
        end
      end
      ST_EDGE0: begin
        cmd.edge_rd0 = 1'b1;
        state_next   = ST_EDGE1;
      end
      ST_EDGE1: begin
        cmd.edge_rd1   = 1'b1;
        cmd.proj_start = 1'b1;
        state_next     = ST_PROJ;
      end
      ST_PROJ: begin
        cmd.proj_step = 1'b1;
        if (sts.proj_done) state_next = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (sts.separates) begin
          res_load   = 1'b1;
          state_next = ST_OUT;
        end else if (sts.edges_done) begin
          res_load   = 1'b1;
          res_coll   = 1'b1;
          state_next = ST_OUT;
        end else begin
          cmd.next_edge = 1'b1;
          state_next    = ST_EDGE0;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          cmd.clear  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

endmodule

@@ rtl/core/cpsat_dp.sv @@
module cpsat_dp import cpsat_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cpsat_cmd_t        cmd,
  output cpsat_sts_t        sts,
  input  logic              which_polygon,
  input  logic signed [15:0] vertex_x,
  input  logic signed [15:0] vertex_y,
  input  logic              last_vertex,
  input  logic              res_load,
  input  logic              res_coll,
  output logic              colliding,
  output logic              separating_polygon,
  output logic [3:0]        separating_edge,
  output logic              overflow_flag
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = COORD_WIDTH + EW + 1;
  localparam int SW = PW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_VERTICES);

  logic [2*COORD_WIDTH-1:0] mem_a [MAX_VERTICES];
  logic [2*COORD_WIDTH-1:0] mem_b [MAX_VERTICES];
  logic [2*COORD_WIDTH-1:0] rd_a, rd_b;

  logic [CW-1:0] count_a, count_b;
  logic          overflowed;
  logic          a_done;

  // sweep registers
  logic          edge_poly;
  logic [CW-1:0] edge_idx;
  logic [CW-1:0] proj_idx;   // runs over A then B, restarting at zero for B
  logic          proj_poly;
  logic          proj_valid; // pipeline stage holds a read
  logic          proj_poly_d;
  logic          proj_last, proj_last_d;
  logic signed [COORD_WIDTH-1:0] x0, y0;
  logic signed [EW-1:0] nx, ny;
  logic signed [PW-1:0] pa_x, pa_y;
  logic signed [SW-1:0] p;
  logic signed [SW-1:0] alo, ahi, blo, bhi;
  logic          a_seen, b_seen;
  logic          mul_valid, mul_poly, mul_last;

  logic signed [COORD_WIDTH-1:0] vx, vy;
  assign vx = COORD_WIDTH'(vertex_x);
  assign vy = COORD_WIDTH'(vertex_y);

  logic [CW-1:0] ecount, enext;
  logic [IW-1:0] rd_addr_a, rd_addr_b;
  logic          rd_sel;   // which store the registered read used
  logic signed [COORD_WIDTH-1:0] rx, ry;

  assign ecount = edge_poly ? count_b : count_a;
  assign enext  = (edge_idx + 1'b1 < ecount) ? edge_idx + 1'b1 : '0;

  always_comb begin
    rd_addr_a = proj_idx[IW-1:0];
    rd_addr_b = proj_idx[IW-1:0];
    if (cmd.edge_rd0 || cmd.store_v) begin
      rd_addr_a = edge_idx[IW-1:0];
      rd_addr_b = edge_idx[IW-1:0];
    end else if (cmd.edge_rd1) begin
      rd_addr_a = enext[IW-1:0];
      rd_addr_b = enext[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_v && !which_polygon && !a_done && count_a < MaxCnt)
      mem_a[count_a[IW-1:0]] <= {vx, vy};
    if (cmd.store_v && which_polygon && count_b < MaxCnt)
      mem_b[count_b[IW-1:0]] <= {vx, vy};
    rd_a <= mem_a[rd_addr_a];
    rd_b <= mem_b[rd_addr_b];
  end

  assign rx = rd_sel ? rd_b[2*COORD_WIDTH-1:COORD_WIDTH] : rd_a[2*COORD_WIDTH-1:COORD_WIDTH];
  assign ry = rd_sel ? rd_b[COORD_WIDTH-1:0] : rd_a[COORD_WIDTH-1:0];

  logic in_b_now;
  assign in_b_now = cmd.store_v && which_polygon;

  // empty: evaluated when B closes; B counts this vertex if room
  assign sts.empty = (count_a == '0) || (count_b == '0 && MaxCnt == '0);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count_a    <= '0;
      count_b    <= '0;
      a_done     <= 1'b0;
      overflowed <= 1'b0;
    end else if (cmd.store_v) begin
      if (!which_polygon) begin
        if (!a_done) begin
          if (count_a < MaxCnt) count_a <= count_a + 1'b1;
          else                  overflowed <= 1'b1;
          if (last_vertex) a_done <= 1'b1;
        end
      end else begin
        if (count_b < MaxCnt) count_b <= count_b + 1'b1;
        else                  overflowed <= 1'b1;
      end
    end
  end

  // edge and projection sweep
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      edge_poly <= 1'b0;
      edge_idx  <= '0;
    end else if (cmd.next_edge) begin
      if (edge_idx + 1'b1 < ecount) begin
        edge_idx <= edge_idx + 1'b1;
      end else begin
        edge_poly <= 1'b1;
        edge_idx  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_sel <= (cmd.edge_rd0 || cmd.edge_rd1) ? edge_poly : proj_poly;
    if (cmd.edge_rd1) begin
      x0 <= rx;
      y0 <= ry;
    end
  end

  // normal formed the cycle after the second read
  logic form_n;
  always_ff @(posedge clk) begin
    if (rst) form_n <= 1'b0;
    else     form_n <= cmd.edge_rd1;
    if (form_n) begin
      nx <= -(EW'(ry) - EW'(y0));
      ny <=  EW'(rx) - EW'(x0);
    end
  end

  // projection: issue reads over A then B, multiply, accumulate
  logic issue;
  assign issue = cmd.proj_step && !proj_last && !form_n;

  always_ff @(posedge clk) begin
    if (rst || cmd.proj_start) begin
      proj_idx   <= '0;
      proj_poly  <= 1'b0;
      proj_last  <= 1'b0;
      proj_valid <= 1'b0;
    end else begin
      proj_valid <= issue;
      if (issue) begin
        proj_poly_d <= proj_poly;
        proj_last_d <= proj_poly && (proj_idx + 1'b1 == count_b);
        if (!proj_poly && proj_idx + 1'b1 == count_a) begin
          proj_poly <= 1'b1;
          proj_idx  <= '0;
        end else if (proj_poly && proj_idx + 1'b1 == count_b) begin
          proj_last <= 1'b1;
        end else begin
          proj_idx <= proj_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.proj_start) mul_valid <= 1'b0;
    else                       mul_valid <= proj_valid;
    if (proj_valid) begin
      pa_x     <= PW'(rx) * PW'(nx);
      pa_y     <= PW'(ry) * PW'(ny);
      mul_poly <= proj_poly_d;
      mul_last <= proj_last_d;
    end
  end

  assign p = SW'(pa_x) + SW'(pa_y);

  always_ff @(posedge clk) begin
    if (rst || cmd.proj_start) begin
      a_seen <= 1'b0;
      b_seen <= 1'b0;
    end else if (mul_valid) begin
      if (!mul_poly) begin
        a_seen <= 1'b1;
        if (!a_seen || p < alo) alo <= p;
        if (!a_seen || p > ahi) ahi <= p;
      end else begin
        b_seen <= 1'b1;
        if (!b_seen || p < blo) blo <= p;
        if (!b_seen || p > bhi) bhi <= p;
      end
    end
  end

  logic done_q;
  always_ff @(posedge clk) begin
    if (rst || cmd.proj_start) done_q <= 1'b0;
    else                       done_q <= mul_valid && mul_last;
  end

  assign sts.proj_done  = done_q;
  assign sts.separates  = ((alo > blo) ? alo : blo) > ((ahi < bhi) ? ahi : bhi);
  assign sts.edges_done = edge_poly && (edge_idx + 1'b1 >= count_b);

  always_ff @(posedge clk) begin
    if (res_load) begin
      overflow_flag <= overflowed || (in_b_now && count_b == MaxCnt);
      if (res_coll || in_b_now) begin
        colliding          <= res_coll;
        separating_polygon <= 1'b0;
        separating_edge    <= '0;
      end else begin
        colliding          <= 1'b0;
        separating_polygon <= edge_poly;
        separating_edge    <= 4'(edge_idx);
      end
    end
  end

endmodule
